>>> rtl/sha1bc_pkg.sv
package sha1bc_pkg;

  // block geometry
  localparam int unsigned NUM_CHAIN   = 5;
  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned NUM_ROUNDS  = 80;

  typedef logic [31:0] word_t;
  typedef logic [2:0]  chain_idx_t;
  typedef logic [3:0]  word_cnt_t;
  typedef logic [6:0]  round_cnt_t;

  // configuration register indexes
  localparam chain_idx_t CFG_IV_A = 3'd0;
  localparam chain_idx_t CFG_IV_B = 3'd1;
  localparam chain_idx_t CFG_IV_C = 3'd2;
  localparam chain_idx_t CFG_IV_D = 3'd3;
  localparam chain_idx_t CFG_IV_E = 3'd4;

  // chaining word that closes an output run
  localparam chain_idx_t IDX_LAST = CFG_IV_E;

  // standard initial chaining value
  localparam word_t IV_A_RESET = 32'h6745_2301;
  localparam word_t IV_B_RESET = 32'hEFCD_AB89;
  localparam word_t IV_C_RESET = 32'h98BA_DCFE;
  localparam word_t IV_D_RESET = 32'h1032_5476;
  localparam word_t IV_E_RESET = 32'hC3D2_E1F0;

  // round constants
  localparam word_t K_CH   = 32'h5A82_7999;
  localparam word_t K_PAR1 = 32'h6ED9_EBA1;
  localparam word_t K_MAJ  = 32'h8F1B_BCDC;
  localparam word_t K_PAR2 = 32'hCA62_C1D6;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } ctrl_state_t;

  typedef enum logic [1:0] {
    STG_CH,
    STG_PAR1,
    STG_MAJ,
    STG_PAR2
  } round_stage_t;

  // controller to datapath commands
  typedef struct packed {
    logic         load_word;   // shift accepted word into schedule window
    logic         load_iv;     // copy iv registers into chaining value
    logic         init_work;   // copy chaining value into working vars
    logic         round_en;    // run one round
    round_stage_t stage;       // round function group
    logic         add_chain;   // fold working vars into chaining value
    chain_idx_t   out_index;   // chaining word on the output
  } dp_cmd_t;

  function automatic word_t round_k(round_stage_t stg);
    word_t k;
    case (stg)
      STG_CH:   k = K_CH;
      STG_PAR1: k = K_PAR1;
      STG_MAJ:  k = K_MAJ;
      STG_PAR2: k = K_PAR2;
      default:  k = K_CH;
    endcase
    return k;
  endfunction

  function automatic word_t round_f(round_stage_t stg, word_t b, word_t c, word_t d);
    word_t f;
    case (stg)
      STG_CH:  f = (b & c) | (~b & d);
      STG_MAJ: f = (b & c) | (b & d) | (c & d);
      default: f = b ^ c ^ d;
    endcase
    return f;
  endfunction

endpackage

>>> rtl/sha1bc_in_if.sv
interface sha1bc_in_if;
  logic                valid;
  logic                ready;
  sha1bc_pkg::word_t   msg_word;
  logic                restart;

  modport source (output valid, output msg_word, output restart, input ready);
  modport sink   (input valid, input msg_word, input restart, output ready);
endinterface

>>> rtl/sha1bc_out_if.sv
interface sha1bc_out_if;
  logic                   valid;
  logic                   ready;
  sha1bc_pkg::word_t      hash_word;
  sha1bc_pkg::chain_idx_t word_index;
  logic                   last;

  modport source (output valid, output hash_word, output word_index, output last,
                  input ready);
  modport sink   (input valid, input hash_word, input word_index, input last,
                  output ready);
endinterface

>>> rtl/sha1bc_ctrl.sv
module sha1bc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_restart,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output sha1bc_pkg::dp_cmd_t cmd
);

  localparam sha1bc_pkg::word_cnt_t  LAST_WORD  =
    sha1bc_pkg::word_cnt_t'(sha1bc_pkg::BLOCK_WORDS - 1);
  localparam sha1bc_pkg::round_cnt_t LAST_ROUND =
    sha1bc_pkg::round_cnt_t'(sha1bc_pkg::NUM_ROUNDS - 1);

  sha1bc_pkg::ctrl_state_t state_r, state_nxt;
  sha1bc_pkg::word_cnt_t   word_cnt_r, word_cnt_nxt;
  sha1bc_pkg::round_cnt_t  round_cnt_r, round_cnt_nxt;
  sha1bc_pkg::chain_idx_t  emit_idx_r, emit_idx_nxt;

  logic                  in_beat;
  logic                  out_beat;
  sha1bc_pkg::word_cnt_t word_eff;

  assign in_beat  = in_valid & in_ready;
  assign out_beat = out_valid & out_ready;
  // restart makes the current beat word zero of a new block
  assign word_eff = in_restart ? '0 : word_cnt_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sha1bc_pkg::ST_LOAD: begin
        if (in_beat && word_eff == LAST_WORD) state_nxt = sha1bc_pkg::ST_ROUND;
      end
      sha1bc_pkg::ST_ROUND: begin
        if (round_cnt_r == LAST_ROUND) state_nxt = sha1bc_pkg::ST_ADD;
      end
      sha1bc_pkg::ST_ADD: begin
        state_nxt = sha1bc_pkg::ST_EMIT;
      end
      sha1bc_pkg::ST_EMIT: begin
        if (out_beat && emit_idx_r == sha1bc_pkg::IDX_LAST) state_nxt = sha1bc_pkg::ST_LOAD;
      end
      default: state_nxt = sha1bc_pkg::ST_LOAD;
    endcase
  end

  // counters
  always_comb begin
    word_cnt_nxt  = word_cnt_r;
    round_cnt_nxt = round_cnt_r;
    emit_idx_nxt  = emit_idx_r;
    if (in_beat) begin
      word_cnt_nxt = (word_eff == LAST_WORD) ? '0 : word_eff + 4'd1;
    end
    if (state_r == sha1bc_pkg::ST_ROUND) begin
      round_cnt_nxt = (round_cnt_r == LAST_ROUND) ? '0 : round_cnt_r + 7'd1;
    end
    if (out_beat) begin
      emit_idx_nxt = (emit_idx_r == sha1bc_pkg::IDX_LAST) ? '0 : emit_idx_r + 3'd1;
    end
  end

  // outputs
  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    cmd           = '0;
    cmd.out_index = emit_idx_r;
    if (round_cnt_r < 7'd20)      cmd.stage = sha1bc_pkg::STG_CH;
    else if (round_cnt_r < 7'd40) cmd.stage = sha1bc_pkg::STG_PAR1;
    else if (round_cnt_r < 7'd60) cmd.stage = sha1bc_pkg::STG_MAJ;
    else                          cmd.stage = sha1bc_pkg::STG_PAR2;
    case (state_r)
      sha1bc_pkg::ST_LOAD: begin
        in_ready      = 1'b1;
        cmd.load_word = in_valid;
        cmd.load_iv   = in_valid & in_restart;
        cmd.init_work = in_valid & (word_eff == LAST_WORD);
      end
      sha1bc_pkg::ST_ROUND: begin
        cmd.round_en = 1'b1;
      end
      sha1bc_pkg::ST_ADD: begin
        cmd.add_chain = 1'b1;
      end
      sha1bc_pkg::ST_EMIT: begin
        out_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sha1bc_pkg::ST_LOAD;
      word_cnt_r  <= '0;
      round_cnt_r <= '0;
      emit_idx_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      word_cnt_r  <= word_cnt_nxt;
      round_cnt_r <= round_cnt_nxt;
      emit_idx_r  <= emit_idx_nxt;
    end
  end

endmodule

>>> rtl/sha1bc_datapath.sv
module sha1bc_datapath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sha1bc_pkg::dp_cmd_t    cmd,
  input  sha1bc_pkg::word_t      in_msg_word,
  input  logic                   cfg_we,
  input  sha1bc_pkg::chain_idx_t cfg_index,
  input  sha1bc_pkg::word_t      cfg_data,
  output sha1bc_pkg::word_t      out_hash_word,
  output sha1bc_pkg::chain_idx_t out_word_index,
  output logic                   out_last
);

  localparam int unsigned NC = sha1bc_pkg::NUM_CHAIN;
  localparam int unsigned NW = sha1bc_pkg::BLOCK_WORDS;

  sha1bc_pkg::word_t iv_r    [NC];
  sha1bc_pkg::word_t chain_r [NC];
  sha1bc_pkg::word_t work_r  [NC];
  sha1bc_pkg::word_t win_r   [NW];

  sha1bc_pkg::word_t a, b, c, d, e;
  sha1bc_pkg::word_t w_cur, w_new, w_x;
  sha1bc_pkg::word_t f_val, k_val, tmp;

  assign a = work_r[0];
  assign b = work_r[1];
  assign c = work_r[2];
  assign d = work_r[3];
  assign e = work_r[4];

  // window holds W[t] .. W[t+15]; the oldest entry feeds the round
  assign w_cur = win_r[0];
  assign w_x   = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
  assign w_new = {w_x[30:0], w_x[31]};

  // one round
  assign f_val = sha1bc_pkg::round_f(cmd.stage, b, c, d);
  assign k_val = sha1bc_pkg::round_k(cmd.stage);
  assign tmp   = {a[26:0], a[31:27]} + f_val + e + k_val + w_cur;

  // iv registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r[0] <= sha1bc_pkg::IV_A_RESET;
      iv_r[1] <= sha1bc_pkg::IV_B_RESET;
      iv_r[2] <= sha1bc_pkg::IV_C_RESET;
      iv_r[3] <= sha1bc_pkg::IV_D_RESET;
      iv_r[4] <= sha1bc_pkg::IV_E_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        sha1bc_pkg::CFG_IV_A: iv_r[0] <= cfg_data;
        sha1bc_pkg::CFG_IV_B: iv_r[1] <= cfg_data;
        sha1bc_pkg::CFG_IV_C: iv_r[2] <= cfg_data;
        sha1bc_pkg::CFG_IV_D: iv_r[3] <= cfg_data;
        sha1bc_pkg::CFG_IV_E: iv_r[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  // chaining value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r[0] <= sha1bc_pkg::IV_A_RESET;
      chain_r[1] <= sha1bc_pkg::IV_B_RESET;
      chain_r[2] <= sha1bc_pkg::IV_C_RESET;
      chain_r[3] <= sha1bc_pkg::IV_D_RESET;
      chain_r[4] <= sha1bc_pkg::IV_E_RESET;
    end else begin
      for (int i = 0; i < NC; i++) begin
        if (cmd.load_iv)        chain_r[i] <= iv_r[i];
        else if (cmd.add_chain) chain_r[i] <= chain_r[i] + work_r[i];
      end
    end
  end

  // working variables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NC; i++) work_r[i] <= '0;
    end else if (cmd.init_work) begin
      for (int i = 0; i < NC; i++) work_r[i] <= chain_r[i];
    end else if (cmd.round_en) begin
      work_r[0] <= tmp;
      work_r[1] <= a;
      work_r[2] <= {b[1:0], b[31:2]};
      work_r[3] <= c;
      work_r[4] <= d;
    end
  end

  // schedule window shift line
  always_ff @(posedge clk) begin
    if (cmd.load_word || cmd.round_en) begin
      for (int i = 0; i < NW - 1; i++) win_r[i] <= win_r[i + 1];
      win_r[NW - 1] <= cmd.load_word ? in_msg_word : w_new;
    end
  end

  // output beat payload
  always_comb begin
    case (cmd.out_index)
      sha1bc_pkg::CFG_IV_A: out_hash_word = chain_r[0];
      sha1bc_pkg::CFG_IV_B: out_hash_word = chain_r[1];
      sha1bc_pkg::CFG_IV_C: out_hash_word = chain_r[2];
      sha1bc_pkg::CFG_IV_D: out_hash_word = chain_r[3];
      default:              out_hash_word = chain_r[4];
    endcase
  end

  assign out_word_index = cmd.out_index;
  assign out_last       = (cmd.out_index == sha1bc_pkg::IDX_LAST);

endmodule

>>> rtl/sha1_block_compress.sv
// SHA-1 block compression over a stream of 32-bit big-endian message words.
// Sixteen input beats make one 64-byte block; a beat with restart set reloads
// the chaining value from the iv registers and becomes word zero of a new
// block. Input beats are taken one per cycle while a block fills. After the
// sixteenth word the block runs the 80 rounds through one shared round unit at
// one round per cycle, adds the working vars into the chaining value, then
// presents five output beats (words a..e, last on e). No input is taken from
// the sixteenth word until the fifth output beat is taken. The iv registers
// are to be written through the cfg port only while idle; the block itself
// does not enforce this. A write takes effect at the next restart.
module sha1_block_compress (
  input  logic                   clk,
  input  logic                   rst_n,
  sha1bc_in_if.sink              in_ch,
  sha1bc_out_if.source           out_ch,
  input  logic                   cfg_we,
  input  sha1bc_pkg::chain_idx_t cfg_index,
  input  sha1bc_pkg::word_t      cfg_data
);

  sha1bc_pkg::dp_cmd_t cmd;

  // sequencer
  sha1bc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_restart (in_ch.restart),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .cmd        (cmd)
  );

  // chaining value, rounds and schedule
  sha1bc_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_msg_word    (in_ch.msg_word),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_hash_word  (out_ch.hash_word),
    .out_word_index (out_ch.word_index),
    .out_last       (out_ch.last)
  );

endmodule
